/* hw/rtl/sspq_pkg.sv */
// Package for the stable sorted priority queue.
// Holds the request and response word types, the stored entry type,
// the operation and status codes, and the sequencer state type. No dependencies.
package sspq_pkg;

	// operation codes carried in the mode field
	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// request word
	typedef struct packed {
		logic               mode;
		logic signed [15:0] priority_req;
		logic        [15:0] item_tag;
	} req_word_t;

	// response word
	typedef struct packed {
		logic        [15:0] removed_tag;
		logic        [15:0] front_tag;
		logic signed [15:0] front_priority;
		logic               empty_res;
		logic               full_res;
		status_t            status;
	} rsp_word_t;

	// one stored queue entry
	typedef struct packed {
		logic signed [15:0] pri;
		logic        [15:0] tag;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_SCAN,
		S_ADD_HEAD,
		S_POP_WAIT,
		S_DONE
	} state_t;

endpackage

/* hw/rtl/sspq_mem.sv */
// Entry storage for the sorted priority queue: one write port, one read port.
// Read data is registered. Depends on sspq_pkg.
module sspq_mem import sspq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  entry_t                   wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output entry_t                   rd_data
);

	entry_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/sspq_ctrl.sv */
// Sequencer of the sorted priority queue: circular pointers, front cache and
// the shared priority comparator that walks the list from the tail on an add.
// Depends on sspq_pkg; drives the ports of sspq_mem.
module sspq_ctrl import sspq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  req_word_t                req,
	output logic                     res_valid,
	input  logic                     res_take,
	output rsp_word_t                res,
	output logic                     mem_wr_en,
	output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
	output entry_t                   mem_wr_data,
	output logic                     mem_rd_en,
	output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
	input  entry_t                   mem_rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   head_q;    // slot of the front entry
	logic [AW-1:0]   tail_q;    // first free slot behind the last entry
	logic [AW-1:0]   ptr_q;     // slot under compare during an add
	logic [AW-1:0]   idx_q;     // list position of ptr_q
	req_word_t       item_q;
	entry_t          front_q;
	logic [15:0]     removed_q;
	status_t         status_q;

	logic            accept;
	logic            is_add;
	logic            q_empty;
	logic            q_full;
	logic            q_one;
	logic            scan_hit;
	logic            idx_zero;
	logic [CW-1:0]   cnt_m1;
	logic [AW-1:0]   head_inc;
	logic [AW-1:0]   tail_inc;
	logic [AW-1:0]   tail_dec;
	logic [AW-1:0]   ptr_inc;
	logic [AW-1:0]   ptr_dec;
	entry_t          new_entry;
	logic            add_done;

	// circular pointer steps
	assign head_inc = (head_q == LAST) ? '0 : head_q + AW'(1);
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + AW'(1);
	assign tail_dec = (tail_q == '0) ? LAST : tail_q - AW'(1);
	assign ptr_inc  = (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
	assign ptr_dec  = (ptr_q == '0) ? LAST : ptr_q - AW'(1);

	assign accept    = req_valid && (state_q == S_IDLE);
	assign is_add    = (req.mode == MODE_ADD);
	assign q_empty   = (count_q == '0);
	assign q_full    = (count_q == FULL_CNT);
	assign q_one     = (count_q == CW'(1));
	assign cnt_m1    = count_q - CW'(1);
	assign idx_zero  = (idx_q == '0);
	assign new_entry = '{pri: item_q.priority_req, tag: item_q.item_tag};

	// shared comparator: stored entry stays ahead when its priority is not lower
	assign scan_hit = (mem_rd_data.pri >= item_q.priority_req);

	assign add_done = ((state_q == S_ADD_SCAN) && scan_hit) || (state_q == S_ADD_HEAD);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_add) begin
						if (q_full) begin
							state_d = S_DONE;
						end else if (q_empty) begin
							state_d = S_ADD_HEAD;
						end else begin
							state_d = S_ADD_RD;
						end
					end else begin
						if (q_empty || q_one) begin
							state_d = S_DONE;
						end else begin
							state_d = S_POP_WAIT;
						end
					end
				end
			end
			S_ADD_RD:   state_d = S_ADD_SCAN;
			S_ADD_SCAN: begin
				if (scan_hit) begin
					state_d = S_DONE;
				end else if (idx_zero) begin
					state_d = S_ADD_HEAD;
				end
			end
			S_ADD_HEAD: state_d = S_DONE;
			S_POP_WAIT: state_d = S_DONE;
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// memory controls and handshake outputs
	always_comb begin
		req_stall   = (state_q != S_IDLE);
		res_valid   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = ptr_inc;
		mem_wr_data = mem_rd_data;
		mem_rd_en   = 1'b0;
		mem_rd_addr = ptr_q;
		case (state_q)
			S_IDLE: begin
				// fetch the entry that becomes the new front on a pop
				mem_rd_en   = accept && !is_add;
				mem_rd_addr = head_inc;
			end
			S_ADD_RD: begin
				mem_rd_en = 1'b1;
			end
			S_ADD_SCAN: begin
				// move the lower entry back one slot, or drop the new one in behind
				mem_wr_en = 1'b1;
				if (scan_hit) begin
					mem_wr_data = new_entry;
				end else if (!idx_zero) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = ptr_dec;
				end
			end
			S_ADD_HEAD: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = head_q;
				mem_wr_data = new_entry;
			end
			S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept && !is_add && !q_empty) begin
				count_q <= cnt_m1;
				head_q  <= head_inc;
			end else if (add_done) begin
				count_q <= count_q + CW'(1);
				tail_q  <= tail_inc;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= req;
			ptr_q     <= tail_dec;
			idx_q     <= cnt_m1[AW-1:0];
			removed_q <= (!is_add && !q_empty) ? front_q.tag : 16'd0;
			if (is_add && q_full) begin
				status_q <= ST_FULL;
			end else if (!is_add && q_empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end
		if ((state_q == S_ADD_SCAN) && !scan_hit && !idx_zero) begin
			ptr_q <= ptr_dec;
			idx_q <= idx_q - AW'(1);
		end
		if (state_q == S_ADD_HEAD) begin
			front_q <= new_entry;
		end
		if (state_q == S_POP_WAIT) begin
			front_q <= mem_rd_data;
		end
	end

	// response word
	always_comb begin
		res.removed_tag    = removed_q;
		res.front_tag      = q_empty ? 16'd0 : front_q.tag;
		res.front_priority = q_empty ? 16'sd0 : front_q.pri;
		res.empty_res      = q_empty;
		res.full_res       = q_full;
		res.status         = status_q;
	end

endmodule

/* hw/rtl/stable_sorted_priority_queue_unit.sv */
// Stable sorted priority queue: top level with the response register.
// Depends on sspq_pkg, sspq_mem and sspq_ctrl.
//
// Usage: a request word on req (valid/stall) either adds a (priority, tag)
// entry or removes the front entry. Entries leave in order of descending
// priority; equal priorities leave in arrival order. Every request gives one
// response word on rsp with the popped tag, the front entry, empty and full
// flags and a status (ok, remove on empty, add on full dropped).
// Operation: entries sit in a circular buffer in one memory. A remove reads
// the next entry to refill the front cache, and skips the wait for that read
// when it finds the queue empty or leaves it empty. An add walks the list
// from the tail, one entry per cycle through the single priority comparator
// and the memory, moving back each entry of lower priority; an add to an
// empty queue writes the head slot directly and a dropped add writes nothing.
// One request is in work at a time; req_stall is high until the response is
// loaded into the output register, and the next request is taken in the
// following cycle at the earliest.
// Reset clears the count and pointers; the queue is empty afterwards and no
// clearing pass is needed. A stalled response holds in the output register;
// one further request may be worked meanwhile and waits until it drains.
module stable_sorted_priority_queue_unit import sspq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	localparam int AW = $clog2(DEPTH);

	logic            res_valid;
	logic            res_take;
	rsp_word_t       res;
	logic            mem_wr_en;
	logic [AW-1:0]   mem_wr_addr;
	entry_t          mem_wr_data;
	logic            mem_rd_en;
	logic [AW-1:0]   mem_rd_addr;
	entry_t          mem_rd_data;
	logic            rsp_valid_q;
	rsp_word_t       rsp_q;

	sspq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	sspq_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// load the response register when it is empty or draining
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* verif/sspq_checker.sv */
// Checker for the stable sorted priority queue: watches the request and response
// channels, keeps its own sorted copy of the queue and compares every response word.
// Depends on sspq_pkg.
module stable_sorted_priority_queue_checker import sspq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_word_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_word_t rsp,
	output int        fail_count,
	output int        pending
);

	// shadow queue, front first, descending priority
	entry_t    slots [DEPTH];
	int        held;
	rsp_word_t owed_snapshots [$];
	int        errors;

	// apply one request word to the shadow queue and return the queue view after it
	function automatic rsp_word_t sorted_queue_step(input req_word_t w);
		rsp_word_t r;
		int        i;
		int        pos;
		r = '0;
		r.status = ST_OK;
		if (w.mode == MODE_ADD) begin
			if (held >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// new entry goes behind every entry of greater or equal priority
				pos = 0;
				while (pos < held && slots[pos].pri >= w.priority_req)
					pos++;
				for (i = held; i > pos; i--)
					slots[i] = slots[i - 1];
				slots[pos].pri = w.priority_req;
				slots[pos].tag = w.item_tag;
				held++;
			end
		end else begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.removed_tag = slots[0].tag;
				for (i = 1; i < held; i++)
					slots[i - 1] = slots[i];
				held--;
			end
		end
		if (held != 0) begin
			r.front_tag      = slots[0].tag;
			r.front_priority = slots[0].pri;
		end
		r.empty_res = (held == 0);
		r.full_res  = (held >= DEPTH);
		return r;
	endfunction

	// response side first, so a word accepted at this edge cannot be matched early
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			held = 0;
			errors = 0;
			owed_snapshots.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_snapshots.size() == 0) begin
					if (errors < 10)
						$display("unexpected response word: %p", rsp);
					errors++;
				end else begin
					want = owed_snapshots.pop_front();
					if (rsp.removed_tag !== want.removed_tag ||
							rsp.front_tag !== want.front_tag ||
							rsp.front_priority !== want.front_priority ||
							rsp.empty_res !== want.empty_res ||
							rsp.full_res !== want.full_res ||
							rsp.status !== want.status) begin
						if (errors < 10) begin
							$display("response mismatch (got / want):");
							$display("  removed_tag %h / %h  front_tag %h / %h",
								rsp.removed_tag, want.removed_tag,
								rsp.front_tag, want.front_tag);
							$display("  front_priority %0d / %0d  empty %b / %b",
								rsp.front_priority, want.front_priority,
								rsp.empty_res, want.empty_res);
							$display("  full %b / %b  status %0d / %0d",
								rsp.full_res, want.full_res, rsp.status, want.status);
						end
						errors++;
					end
				end
			end
			if (req_valid && !req_stall)
				owed_snapshots.push_back(sorted_queue_step(req));
			fail_count <= errors;
			pending <= owed_snapshots.size();
		end
	end

endmodule

/* verif/tb_stable_sorted_priority_queue_unit.sv */
// Testbench top for the stable sorted priority queue: clock, reset, request
// stimulus, response stall and the verdict. Depends on sspq_pkg, the queue unit
// and stable_sorted_priority_queue_checker.
module tb_stable_sorted_priority_queue_unit;
	import sspq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 250;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;
	int        fail_count;
	int        pending;
	int        cycles    = 0;
	int        gap_pct   = 0;
	int        stall_pct = 0;

	// idle percentages per phase: none, sender, receiver, both
	int phase_gap   [4] = '{0, 72, 0, 19};
	int phase_stall [4] = '{0, 0, 72, 19};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	stable_sorted_priority_queue_unit #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	stable_sorted_priority_queue_checker #(.DEPTH(DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// receiver stall, redrawn every cycle
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// present one word, with random idle cycles ahead, and hold it until taken
	task automatic send_word(input req_word_t w);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	task automatic send_add(input logic signed [15:0] pri, input logic [15:0] tag);
		req_word_t w;
		w.mode = MODE_ADD;
		w.priority_req = pri;
		w.item_tag = tag;
		send_word(w);
	endtask

	// payload of a remove is ignored by the block, so it carries noise
	task automatic send_remove();
		req_word_t w;
		w.mode = MODE_REMOVE;
		w.priority_req = 16'($urandom);
		w.item_tag = 16'($urandom);
		send_word(w);
	endtask

	// random word: ties from a narrow band, the extremes, or anything
	function automatic req_word_t random_word(input int add_pct);
		req_word_t w;
		w.mode = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_REMOVE;
		case ($urandom_range(3))
			0: w.priority_req = 16'($urandom_range(3)) - 16'd2;
			1: w.priority_req = $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: w.priority_req = 16'($urandom);
		endcase
		w.item_tag = 16'($urandom);
		return w;
	endfunction

	initial begin
		int ph;
		int n;
		int add_pct;
		add_pct = 50;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: remove on empty, extremes, ties, fill up, add on full, drain some
		send_remove();
		send_add(16'sd0, 16'h0001);
		send_add(-16'sd1, 16'hffff);
		send_add(16'sh7fff, 16'h0000);
		send_add(16'sh8000, 16'h0002);
		send_add(16'sd5, 16'h0010);
		send_add(16'sd5, 16'h0011);
		send_add(16'sd5, 16'h0012);
		send_add(16'sh7fff, 16'h0003);
		send_add(16'sh8000, 16'h0004);
		send_add(16'sd0, 16'h0005);
		send_add(16'sd1, 16'h0006);
		send_add(-16'sd2, 16'h0007);
		send_add(16'sd5, 16'h0013);
		send_add(16'sd100, 16'h8000);
		send_add(-16'sd100, 16'h7fff);
		send_add(16'sd0, 16'h0008);
		send_add(16'sd5, 16'haaaa);
		repeat (6) send_remove();

		// random phases; the add bias swings so the queue runs full and empty
		for (ph = 0; ph < 4; ph++) begin
			gap_pct = phase_gap[ph];
			stall_pct <= phase_stall[ph];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 32 == 0)
					case ($urandom_range(2))
						0: add_pct = 85;
						1: add_pct = 50;
						default: add_pct = 15;
					endcase
				send_word(random_word(add_pct));
			end
		end
		req_valid <= 1'b0;
		stall_pct <= 0;

		// drain, then let the longest add walk pass before the verdict
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
